@@ hdl/bpfa_pkg.sv @@
package bpfa_pkg;

    localparam int WORD_W   = 16;
    localparam int FRAME_W  = 7;
    localparam int PAGE_W   = 6;
    localparam int FNUM_W   = 6;
    localparam int STATUS_W = 3;
    localparam int PSIZE_W  = 13;
    localparam int FCNT_W   = 7;
    localparam int NUM_W    = 17;
    localparam int REM_W    = 13;
    localparam int STEP_W   = 5;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [STEP_W-1:0] DIV_STEPS = 5'd17;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_GRANTED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREE_IGNORE = 3'd4;

    // register select is paddr[2]
    localparam logic REG_PAGE_SIZE   = 1'b0;
    localparam logic REG_FRAME_COUNT = 1'b1;

    localparam logic [PSIZE_W-1:0] PAGE_SIZE_RESET   = 13'd16;
    localparam logic [FCNT_W-1:0]  FRAME_COUNT_RESET = 7'd64;

    typedef struct packed {
        logic               kind;
        logic [WORD_W-1:0]  word_count;
        logic [FRAME_W-1:0] frame_to_free;
        logic               last_of_batch;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   page_index;
        logic [FNUM_W-1:0]   frame_number;
        logic                last;
        logic [FRAME_W-1:0]  free_frames;
    } t_res;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
    } t_div_stat;

endpackage

@@ hdl/bpfa_div.sv @@
module bpfa_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [bpfa_pkg::NUM_W-1:0]    i_num,
    input  logic [bpfa_pkg::PSIZE_W-1:0]  i_den,
    output bpfa_pkg::t_div_stat           o_stat
);

    logic [bpfa_pkg::REM_W-1:0]   r_rem, n_rem;
    logic [bpfa_pkg::NUM_W-1:0]   r_quo, n_quo;
    logic [bpfa_pkg::PSIZE_W-1:0] r_den, n_den;
    logic [bpfa_pkg::STEP_W-1:0]  r_step, n_step;
    logic                         r_run, n_run;
    logic                         r_done, n_done;
    logic [bpfa_pkg::REM_W+1:0]   trial;

    // one restoring step per cycle, numerator shifted out msb first
    assign trial = {1'b0, r_rem, r_quo[bpfa_pkg::NUM_W-1]} - {2'b00, r_den};

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_step = r_step;
        n_run  = r_run;
        n_done = r_done;
        if (i_go) begin
            n_rem  = '0;
            n_quo  = i_num;
            n_den  = i_den;
            n_step = '0;
            n_run  = 1'b1;
            n_done = 1'b0;
        end else if (r_run) begin
            if (trial[bpfa_pkg::REM_W+1]) begin
                n_rem = {r_rem[bpfa_pkg::REM_W-2:0], r_quo[bpfa_pkg::NUM_W-1]};
                n_quo = {r_quo[bpfa_pkg::NUM_W-2:0], 1'b0};
            end else begin
                n_rem = trial[bpfa_pkg::REM_W-1:0];
                n_quo = {r_quo[bpfa_pkg::NUM_W-2:0], 1'b1};
            end
            n_step = r_step + 1'b1;
            if (r_step == bpfa_pkg::DIV_STEPS - 1'b1) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_stat.done     = r_done;
    assign o_stat.quotient = r_quo;

endmodule

@@ hdl/bitmap_page_frame_allocator_top.sv @@
// channel  | handshake                      | payload
// ---------+--------------------------------+---------------------------
// command  | start, busy (taken: start&!busy)| i_cmd  (t_cmd)
// result   | o_res_strobe, one cycle, no stall| o_res (t_res)
// config   | apb psel/penable/pwrite, pready=1| paddr, pwdata, prdata
//
// every command first scans all MAX_FRAMES bitmap entries, one per cycle, to count
// free frames; for an allocate the 17-step page-count divider runs alongside the scan
// a free then decides at once; an allocate decision waits for the divider to finish
// unless the size is zero, and a grant then scans from frame 0 until every page has a frame
// synchronous active-low reset clears the bitmap; no clearing pass is needed
// results cannot be stalled; busy stays high until the last result is issued
module bitmap_page_frame_allocator_top #(
    parameter int MAX_FRAMES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bpfa_pkg::t_cmd                i_cmd,
    output logic                          o_res_strobe,
    output bpfa_pkg::t_res                o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpfa_pkg::ADDR_W-1:0]   paddr,
    input  logic [bpfa_pkg::DATA_W-1:0]   pwdata,
    output logic [bpfa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_FRAMES - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_GRANT  = 3'd3;

    logic [2:0]                          r_state, n_state;
    logic [IW-1:0]                       r_idx, n_idx;
    logic [bpfa_pkg::FRAME_W-1:0]        r_cnt, n_cnt;
    logic [MAX_FRAMES-1:0]               r_busy, n_busy;
    logic [bpfa_pkg::PSIZE_W-1:0]        r_page_size;
    logic [bpfa_pkg::FCNT_W-1:0]         r_frame_count;
    logic                                r_strobe, n_strobe;
    bpfa_pkg::t_res                      r_res, n_res;
    bpfa_pkg::t_cmd                      r_cmd, n_cmd;
    logic                                r_freed, n_freed;
    logic [bpfa_pkg::FRAME_W-1:0]        r_pages, n_pages;
    logic [bpfa_pkg::FRAME_W-1:0]        r_final, n_final;
    logic [bpfa_pkg::FRAME_W-1:0]        r_granted, n_granted;

    logic [bpfa_pkg::FRAME_W-1:0]        lim;
    logic [bpfa_pkg::PSIZE_W-1:0]        ps_eff;
    logic [bpfa_pkg::NUM_W-1:0]          div_num;
    logic                                accept;
    logic                                div_go;
    logic                                cfg_wr;
    logic                                idx_free;
    bpfa_pkg::t_div_stat                 div_stat;

    assign lim = (r_frame_count > bpfa_pkg::FCNT_W'(MAX_FRAMES))
               ? bpfa_pkg::FRAME_W'(MAX_FRAMES) : r_frame_count;
    assign ps_eff  = (r_page_size == '0) ? bpfa_pkg::PSIZE_W'(1) : r_page_size;
    assign div_num = {1'b0, i_cmd.word_count} + {4'b0000, ps_eff} - 1'b1;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign div_go = accept && (i_cmd.kind == bpfa_pkg::KIND_ALLOC);
    assign cfg_wr = psel && penable && pwrite && pready;

    assign idx_free = (bpfa_pkg::FRAME_W'(r_idx) < lim) && !r_busy[r_idx];

    bpfa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (div_go),
        .i_num   (div_num),
        .i_den   (ps_eff),
        .o_stat  (div_stat)
    );

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_busy    = r_busy;
        n_strobe  = 1'b0;
        n_res     = r_res;
        n_cmd     = r_cmd;
        n_freed   = r_freed;
        n_pages   = r_pages;
        n_final   = r_final;
        n_granted = r_granted;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd   = i_cmd;
                    n_idx   = '0;
                    n_cnt   = '0;
                    n_freed = 1'b0;
                    if (i_cmd.kind == bpfa_pkg::KIND_FREE && i_cmd.frame_to_free < lim) begin
                        if (r_busy[i_cmd.frame_to_free[IW-1:0]]) begin
                            n_busy[i_cmd.frame_to_free[IW-1:0]] = 1'b0;
                            n_freed = 1'b1;
                        end
                    end
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (idx_free) begin
                    n_cnt = r_cnt + 1'b1;
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_res.page_index   = '0;
                n_res.frame_number = '0;
                n_res.last         = 1'b1;
                n_res.free_frames  = r_cnt;
                if (r_cmd.kind == bpfa_pkg::KIND_FREE) begin
                    n_strobe   = 1'b1;
                    n_res.last = r_cmd.last_of_batch;
                    if (r_freed) begin
                        n_res.status       = bpfa_pkg::ST_FREED;
                        n_res.frame_number = r_cmd.frame_to_free[bpfa_pkg::FNUM_W-1:0];
                    end else begin
                        n_res.status = bpfa_pkg::ST_FREE_IGNORE;
                    end
                    n_state = S_IDLE;
                end else if (r_cmd.word_count == '0) begin
                    n_strobe     = 1'b1;
                    n_res.status = bpfa_pkg::ST_BAD_SIZE;
                    n_state      = S_IDLE;
                end else if (div_stat.done) begin
                    if (div_stat.quotient > {10'd0, r_cnt}) begin
                        n_strobe     = 1'b1;
                        n_res.status = bpfa_pkg::ST_NO_ROOM;
                        n_state      = S_IDLE;
                    end else begin
                        n_pages   = div_stat.quotient[bpfa_pkg::FRAME_W-1:0];
                        n_final   = r_cnt - div_stat.quotient[bpfa_pkg::FRAME_W-1:0];
                        n_granted = '0;
                        n_idx     = '0;
                        n_state   = S_GRANT;
                    end
                end
            end
            S_GRANT: begin
                // enough free frames below the limit were counted, so this ends
                if (idx_free) begin
                    n_busy[r_idx]      = 1'b1;
                    n_strobe           = 1'b1;
                    n_res.status       = bpfa_pkg::ST_GRANTED;
                    n_res.page_index   = r_granted[bpfa_pkg::PAGE_W-1:0];
                    n_res.frame_number = bpfa_pkg::FNUM_W'(r_idx);
                    n_res.last         = (r_granted + 1'b1 == r_pages);
                    n_res.free_frames  = r_final;
                    n_granted          = r_granted + 1'b1;
                    if (r_granted + 1'b1 == r_pages) begin
                        n_state = S_IDLE;
                    end
                end
                n_idx = r_idx + 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_busy        <= '0;
            r_strobe      <= 1'b0;
            r_page_size   <= bpfa_pkg::PAGE_SIZE_RESET;
            r_frame_count <= bpfa_pkg::FRAME_COUNT_RESET;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
            if (cfg_wr) begin
                if (paddr[2] == bpfa_pkg::REG_PAGE_SIZE) begin
                    r_page_size <= pwdata[bpfa_pkg::PSIZE_W-1:0];
                end else begin
                    r_frame_count <= pwdata[bpfa_pkg::FCNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cnt     <= n_cnt;
        r_res     <= n_res;
        r_cmd     <= n_cmd;
        r_freed   <= n_freed;
        r_pages   <= n_pages;
        r_final   <= n_final;
        r_granted <= n_granted;
    end

    always_comb begin
        if (paddr[2] == bpfa_pkg::REG_FRAME_COUNT) begin
            prdata = {{(bpfa_pkg::DATA_W-bpfa_pkg::FCNT_W){1'b0}}, r_frame_count};
        end else begin
            prdata = {{(bpfa_pkg::DATA_W-bpfa_pkg::PSIZE_W){1'b0}}, r_page_size};
        end
    end

    assign pready       = 1'b1;
    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

endmodule
